[src/pms_pkg.sv]
// Shared constants, register codes and state type for the pointer motion smoother.
package pms_pkg;

  localparam int HISTORY_DEPTH = 10;
  localparam int HIST_W        = 13;
  localparam int ACC_W         = HIST_W + HISTORY_DEPTH;
  localparam int MAG_W         = HIST_W + 1;
  localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam int TICK_W   = 16;
  localparam int CUR_W    = 12;
  localparam int CTR_W    = 11;
  localparam int THR_W    = 20;
  localparam int ELAPSE_W = 21;
  localparam int REL_W    = 11;

  // reciprocal of ten, exact for magnitudes below 2^14
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(6554);
  localparam int PROD_W      = MAG_W + RECIP_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = THR_W;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOCK      = CFG_IDX_W'(3);

  localparam logic [CTR_W-1:0]  CENTER_X_RST  = CTR_W'(320);
  localparam logic [CTR_W-1:0]  CENTER_Y_RST  = CTR_W'(240);
  localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(16667);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_ABS,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic left_pressed;
    logic left_held;
    logic right_pressed;
    logic right_held;
    logic recenter;
  } flags_t;

endpackage

[src/pointer_motion_smoother.sv]
// Top level of the pointer motion smoother: tick sequencer, history and output register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one tick per transfer: elapsed
//   microseconds, absolute cursor position and both button levels. Output
//   channel (out_valid / out_stall) returns one result per tick: smoothed
//   motion, pressed/held per button and the recenter request.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   center point, the step threshold and the lock enable; cfg_ready is always
//   high and unknown indexes are ignored. Write only while idle.
//   A tick with no sampling step is in the output register in the cycle after
//   its transfer. A sampling tick passes through S_ACC, one Horner step of
//   the shared adder per history entry, then S_ABS to take the magnitude,
//   S_DIV to scale by the reciprocal of ten and S_OUT to load the output.
//   Throughput is one tick per cycle without sampling or receiver stall.
//   Reset clears the history, button state and smoothed value and restores
//   the register defaults. While the receiver stalls, the result holds and
//   in_stall stays high until the output register frees up.
module pointer_motion_smoother (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pms_pkg::TICK_W-1:0]          in_tick_us,
  input  logic [pms_pkg::CUR_W-1:0]           in_cursor_x,
  input  logic [pms_pkg::CUR_W-1:0]           in_cursor_y,
  input  logic                                in_left_level,
  input  logic                                in_right_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pms_pkg::REL_W-1:0]    out_rel_x,
  output logic signed [pms_pkg::REL_W-1:0]    out_rel_y,
  output logic                                out_left_pressed,
  output logic                                out_left_held,
  output logic                                out_right_pressed,
  output logic                                out_right_held,
  output logic                                out_recenter,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pms_pkg::*;

  state_t state_r, state_nxt;

  logic [CTR_W-1:0]    center_x_r, center_y_r;
  logic [THR_W-1:0]    threshold_r;
  logic                lock_r;

  logic signed [HIST_W-1:0] hist_x_r [HISTORY_DEPTH];
  logic signed [HIST_W-1:0] hist_y_r [HISTORY_DEPTH];
  logic [ELAPSE_W-1:0] elapsed_r, elapsed_nxt;
  logic                first_r;
  logic [1:0]          buttons_r;
  logic signed [REL_W-1:0] smooth_x_r, smooth_y_r;

  logic [IDX_W-1:0]         k_r;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r, acc_x_nxt, acc_y_nxt;
  logic signed [REL_W-1:0]  div_x, div_y;
  flags_t                   flags_r, flags_now;

  logic in_fire, out_free, over, sample, out_load, div_load, last_step;
  logic signed [HIST_W-1:0] off_x, off_y;

  logic                    out_valid_r;
  logic signed [REL_W-1:0] out_rel_x_r, out_rel_y_r;
  flags_t                  out_flags_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_fire   = in_valid && !in_stall;

  assign elapsed_nxt = elapsed_r + ELAPSE_W'(in_tick_us);
  assign over        = elapsed_nxt > ELAPSE_W'(threshold_r);
  assign sample      = over && lock_r && !first_r;
  assign last_step   = (k_r == IDX_W'(HISTORY_DEPTH - 1));

  assign off_x = HIST_W'({1'b0, in_cursor_x}) - HIST_W'({2'b0, center_x_r});
  assign off_y = HIST_W'({1'b0, in_cursor_y}) - HIST_W'({2'b0, center_y_r});

  always_comb begin
    flags_now.left_pressed  = !buttons_r[0] && in_left_level;
    flags_now.left_held     = buttons_r[0] && in_left_level;
    flags_now.right_pressed = !buttons_r[1] && in_right_level;
    flags_now.right_held    = buttons_r[1] && in_right_level;
    flags_now.recenter      = over && lock_r;
  end

  pms_mac u_mac_x (.acc_i(acc_x_r), .hist_i(hist_x_r[k_r]), .acc_o(acc_x_nxt));
  pms_mac u_mac_y (.acc_i(acc_y_r), .hist_i(hist_y_r[k_r]), .acc_o(acc_y_nxt));

  pms_div10 u_div_x (.clk(clk), .load(div_load), .acc_i(acc_x_r), .rel_o(div_x));
  pms_div10 u_div_y (.clk(clk), .load(div_load), .acc_i(acc_y_r), .rel_o(div_y));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire && sample) state_nxt = S_ACC;
      S_ACC:  if (last_step) state_nxt = S_ABS;
      S_ABS:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    div_load = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
        out_load = in_fire && !sample;
      end
      S_ABS: div_load = 1'b1;
      S_OUT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= CENTER_X_RST;
      center_y_r  <= CENTER_Y_RST;
      threshold_r <= THRESHOLD_RST;
      lock_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X:  center_x_r  <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:  center_y_r  <= cfg_data[CTR_W-1:0];
        REG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        REG_LOCK:      lock_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      first_r    <= 1'b1;
      buttons_r  <= '0;
      smooth_x_r <= '0;
      smooth_y_r <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_x_r[i] <= '0;
        hist_y_r[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        buttons_r <= {in_right_level, in_left_level};
        elapsed_r <= over ? '0 : elapsed_nxt;
        if (over && lock_r) first_r <= 1'b0;
        if (sample) begin
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_x_r[i] <= hist_x_r[i-1];
            hist_y_r[i] <= hist_y_r[i-1];
          end
          hist_x_r[0] <= off_x;
          hist_y_r[0] <= off_y;
        end
      end
      if (state_r == S_DIV) begin
        smooth_x_r <= div_x;
        smooth_y_r <= div_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      flags_r <= flags_now;
      k_r     <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (state_r == S_ACC) begin
      k_r     <= last_step ? k_r : k_r + IDX_W'(1);
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rel_x_r <= smooth_x_r;
      out_rel_y_r <= smooth_y_r;
      out_flags_r <= (state_r == S_OUT) ? flags_r : flags_now;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rel_x         = out_rel_x_r;
  assign out_rel_y         = out_rel_y_r;
  assign out_left_pressed  = out_flags_r.left_pressed;
  assign out_left_held     = out_flags_r.left_held;
  assign out_right_pressed = out_flags_r.right_pressed;
  assign out_right_held    = out_flags_r.right_held;
  assign out_recenter      = out_flags_r.recenter;

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && sample |=> state_r == S_ACC)
    else $error("sampling tick did not start accumulation");

  a_acc_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC && last_step |=> state_r == S_ABS)
    else $error("accumulation ran past the last history entry");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !sample |=> out_valid_r)
    else $error("non-sampling tick produced no result");

  a_first_locked: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_r) |-> $past(lock_r))
    else $error("first sample cleared while unlocked");

endmodule

[src/pms_mac.sv]
// Shared Horner step: doubles the running sum and adds one history entry.
module pms_mac (
  input  logic signed [pms_pkg::ACC_W-1:0]  acc_i,
  input  logic signed [pms_pkg::HIST_W-1:0] hist_i,
  output logic signed [pms_pkg::ACC_W-1:0]  acc_o
);
  import pms_pkg::*;

  assign acc_o = {acc_i[ACC_W-2:0], 1'b0} + {{(ACC_W-HIST_W){hist_i[HIST_W-1]}}, hist_i};

endmodule

[src/pms_div10.sv]
// Scales the weighted sum down by 10 * 2^(depth-1), truncating toward zero, with saturation.
module pms_div10 (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [pms_pkg::ACC_W-1:0]  acc_i,
  output logic signed [pms_pkg::REL_W-1:0]  rel_o
);
  import pms_pkg::*;

  logic             neg_r;
  logic [MAG_W-1:0] mag_r;
  logic [ACC_W-1:0] abs_val;
  logic [PROD_W-1:0] prod;
  logic [REL_W:0]   quot;

  assign abs_val = acc_i[ACC_W-1] ? (~acc_i + ACC_W'(1)) : acc_i;

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= acc_i[ACC_W-1];
      mag_r <= abs_val[ACC_W-1:HISTORY_DEPTH-1];
    end
  end

  assign prod = PROD_W'(mag_r) * PROD_W'(RECIP_TEN);
  assign quot = (REL_W + 1)'(prod[PROD_W-1:RECIP_SHIFT]);

  always_comb begin
    if (neg_r) begin
      if (quot > (REL_W + 1)'(1024)) begin
        rel_o = REL_W'(-1024);
      end else begin
        rel_o = REL_W'(~quot + (REL_W + 1)'(1));
      end
    end else begin
      if (quot > (REL_W + 1)'(1023)) begin
        rel_o = REL_W'(1023);
      end else begin
        rel_o = quot[REL_W-1:0];
      end
    end
  end

endmodule

[dv/pms_checker.sv]
// Checker for the pointer motion smoother: predicts each tick's result and compares transfers.
`timescale 1ns / 100ps

module pms_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [pms_pkg::TICK_W-1:0]        in_tick_us,
  input  logic [pms_pkg::CUR_W-1:0]         in_cursor_x,
  input  logic [pms_pkg::CUR_W-1:0]         in_cursor_y,
  input  logic                              in_left_level,
  input  logic                              in_right_level,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [pms_pkg::REL_W-1:0]  out_rel_x,
  input  logic signed [pms_pkg::REL_W-1:0]  out_rel_y,
  input  logic                              out_left_pressed,
  input  logic                              out_left_held,
  input  logic                              out_right_pressed,
  input  logic                              out_right_held,
  input  logic                              out_recenter,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                mismatch_count,
  output int                                results_due
);
  import pms_pkg::*;

  typedef struct packed {
    logic signed [REL_W-1:0] rel_x;
    logic signed [REL_W-1:0] rel_y;
    flags_t                  flags;
  } motion_result_t;

  logic [CTR_W-1:0]         ctr_x;
  logic [CTR_W-1:0]         ctr_y;
  logic [THR_W-1:0]         threshold;
  logic                     lock_on;

  logic signed [HIST_W-1:0] hist_dx [HISTORY_DEPTH];
  logic signed [HIST_W-1:0] hist_dy [HISTORY_DEPTH];
  int unsigned              hist_fill;
  logic [ELAPSE_W-1:0]      elapsed;
  logic                     awaiting_first;
  logic [1:0]               btn_now;
  logic [1:0]               btn_prev;
  logic signed [REL_W-1:0]  motion_x;
  logic signed [REL_W-1:0]  motion_y;

  motion_result_t           motion_q [$];
  int                       reported;

  // sum(entry k * 2^(depth-1-k)) / (10 * 2^(depth-1)), truncated toward zero, saturated
  function automatic logic signed [REL_W-1:0] weighted_motion(input logic use_y);
    longint acc;
    longint q;
    longint entry;
    acc = 0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (k < hist_fill) begin
        entry = use_y ? longint'(hist_dy[k]) : longint'(hist_dx[k]);
        acc += entry * (longint'(1) << (HISTORY_DEPTH - 1 - k));
      end
    end
    q = acc / (longint'(10) * (longint'(1) << (HISTORY_DEPTH - 1)));
    if (q > 1023) q = 1023;
    if (q < -1024) q = -1024;
    return q[REL_W-1:0];
  endfunction

  task automatic predict_tick();
    motion_result_t r;
    btn_prev = btn_now;
    btn_now  = {in_right_level, in_left_level};
    r.flags.recenter = 1'b0;
    elapsed = elapsed + ELAPSE_W'(in_tick_us);
    if (elapsed > ELAPSE_W'(threshold)) begin
      if (lock_on) begin
        if (!awaiting_first) begin
          for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
            hist_dx[k] = hist_dx[k-1];
            hist_dy[k] = hist_dy[k-1];
          end
          hist_dx[0] = HIST_W'(int'(in_cursor_x) - int'(ctr_x));
          hist_dy[0] = HIST_W'(int'(in_cursor_y) - int'(ctr_y));
          if (hist_fill < HISTORY_DEPTH) hist_fill++;
          motion_x = weighted_motion(1'b0);
          motion_y = weighted_motion(1'b1);
        end
        awaiting_first   = 1'b0;
        r.flags.recenter = 1'b1;
      end
      elapsed = '0;
    end
    r.rel_x               = motion_x;
    r.rel_y               = motion_y;
    r.flags.left_pressed  = ~btn_prev[0] & btn_now[0];
    r.flags.left_held     = btn_prev[0] & btn_now[0];
    r.flags.right_pressed = ~btn_prev[1] & btn_now[1];
    r.flags.right_held    = btn_prev[1] & btn_now[1];
    motion_q.push_back(r);
  endtask

  always @(posedge clk) begin
    motion_result_t got;
    motion_result_t want;
    if (!rst_n) begin
      mismatch_count = 0;
      reported       = 0;
      ctr_x          = CENTER_X_RST;
      ctr_y          = CENTER_Y_RST;
      threshold      = THRESHOLD_RST;
      lock_on        = 1'b0;
      hist_fill      = 0;
      elapsed        = '0;
      awaiting_first = 1'b1;
      btn_now        = '0;
      btn_prev       = '0;
      motion_x       = '0;
      motion_y       = '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_dx[k] = '0;
        hist_dy[k] = '0;
      end
      motion_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X:  ctr_x = cfg_data[CTR_W-1:0];
          REG_CENTER_Y:  ctr_y = cfg_data[CTR_W-1:0];
          REG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          REG_LOCK:      lock_on = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.rel_x               = out_rel_x;
        got.rel_y               = out_rel_y;
        got.flags.left_pressed  = out_left_pressed;
        got.flags.left_held     = out_left_held;
        got.flags.right_pressed = out_right_pressed;
        got.flags.right_held    = out_right_held;
        got.flags.recenter      = out_recenter;
        if (motion_q.size() == 0) begin
          mismatch_count++;
          if (reported < 10)
            $display("%0t: result transfer with nothing expected: x=%0d y=%0d flags=%b",
                     $time, got.rel_x, got.rel_y, got.flags);
          reported++;
        end else begin
          want = motion_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (reported < 10)
              $display("%0t: mismatch: expected x=%0d y=%0d flags=%b, got x=%0d y=%0d flags=%b",
                       $time, want.rel_x, want.rel_y, want.flags,
                       got.rel_x, got.rel_y, got.flags);
            reported++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_tick();
    end
    results_due = motion_q.size();
  end

endmodule

[dv/testbench.sv]
// Testbench top for the pointer motion smoother: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import pms_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_TICKS = 300;

  logic                    clk;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [TICK_W-1:0]       in_tick_us     = '0;
  logic [CUR_W-1:0]        in_cursor_x    = '0;
  logic [CUR_W-1:0]        in_cursor_y    = '0;
  logic                    in_left_level  = 1'b0;
  logic                    in_right_level = 1'b0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic signed [REL_W-1:0] out_rel_x;
  logic signed [REL_W-1:0] out_rel_y;
  logic                    out_left_pressed;
  logic                    out_left_held;
  logic                    out_right_pressed;
  logic                    out_right_held;
  logic                    out_recenter;
  logic                    cfg_valid      = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data       = '0;

  int   mismatch_count;
  int   results_due;
  int   send_idle_pct = 12;
  int   recv_idle_pct = 53;
  logic hold_req      = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_left     = 0;
  int   cycle_count;

  pointer_motion_smoother u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tick_us       (in_tick_us),
    .in_cursor_x      (in_cursor_x),
    .in_cursor_y      (in_cursor_y),
    .in_left_level    (in_left_level),
    .in_right_level   (in_right_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rel_x        (out_rel_x),
    .out_rel_y        (out_rel_y),
    .out_left_pressed (out_left_pressed),
    .out_left_held    (out_left_held),
    .out_right_pressed(out_right_pressed),
    .out_right_held   (out_right_held),
    .out_recenter     (out_recenter),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  pms_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tick_us       (in_tick_us),
    .in_cursor_x      (in_cursor_x),
    .in_cursor_y      (in_cursor_y),
    .in_left_level    (in_left_level),
    .in_right_level   (in_right_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rel_x        (out_rel_x),
    .out_rel_y        (out_rel_y),
    .out_left_pressed (out_left_pressed),
    .out_left_held    (out_left_held),
    .out_right_pressed(out_right_pressed),
    .out_right_held   (out_right_held),
    .out_recenter     (out_recenter),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .results_due      (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_tick(input logic [TICK_W-1:0] tick, input logic [CUR_W-1:0] cx,
                           input logic [CUR_W-1:0] cy, input logic left, input logic right);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_tick_us     <= tick;
    in_cursor_x    <= cx;
    in_cursor_y    <= cy;
    in_left_level  <= left;
    in_right_level <= right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain every outstanding result, then allow the sampling latency to pass
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (HISTORY_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bits are randomized to check that the block masks them off
  task automatic apply_setting(input logic [CTR_W-1:0] cx, input logic [CTR_W-1:0] cy,
                               input logic [THR_W-1:0] thr, input logic lock);
    write_reg(REG_CENTER_X, {9'($urandom), cx});
    write_reg(REG_CENTER_Y, {9'($urandom), cy});
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_LOCK, {19'($urandom), lock});
    write_reg(CFG_IDX_W'($urandom_range(255, 4)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_ticks(input int count);
    logic [TICK_W-1:0] tick;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       tick = '0;
        1:       tick = '1;
        default: tick = TICK_W'($urandom);
      endcase
      send_tick(tick, CUR_W'($urandom), CUR_W'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unlocked, button edges only
    send_tick('0, '0, '0, 1'b0, 1'b0);
    send_tick('1, '1, '1, 1'b1, 1'b0);
    send_tick(TICK_W'(1000), '0, '1, 1'b1, 1'b1);
    send_tick(TICK_W'(1000), '1, '0, 1'b0, 1'b1);
    send_tick('0, '0, '0, 1'b0, 1'b0);
    settle();

    // zero threshold, corner center: first locked step, then fill past full history
    apply_setting('0, '0, '0, 1'b1);
    send_tick('0, '1, '1, 1'b1, 1'b1);
    send_tick(TICK_W'(1), '1, '1, 1'b1, 1'b1);
    for (int i = 0; i < 12; i++)
      send_tick(TICK_W'(1), (i % 3 == 0) ? '0 : '1, (i % 2 == 0) ? '1 : '0,
                1'(i), 1'(i >> 1));
    settle();

    apply_setting('1, '1, THR_W'(1), 1'b1);
    send_tick(TICK_W'(1), '0, '0, 1'b0, 1'b0);
    send_tick(TICK_W'(1), '0, '0, 1'b1, 1'b0);
    send_tick(TICK_W'(2), '1, '1, 1'b0, 1'b1);
    send_tick('1, '0, '1, 1'b1, 1'b1);
    settle();

    apply_setting(CTR_W'($urandom), CTR_W'($urandom), THR_W'(16667), 1'b1);
    random_ticks(PHASE_TICKS);
    settle();
    apply_setting(CTR_W'($urandom), CTR_W'($urandom), '0, 1'b1);
    random_ticks(PHASE_TICKS);
    settle();

    send_idle_pct <= 53;
    recv_idle_pct <= 12;
    apply_setting(CTR_W'($urandom), CTR_W'($urandom), THR_W'($urandom), 1'b0);
    random_ticks(PHASE_TICKS);
    settle();
    apply_setting('1, '1, THR_W'(1000000), 1'b1);
    random_ticks(PHASE_TICKS);
    settle();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    apply_setting('0, '0, '1, 1'b1);
    hold_req <= 1'b1;
    random_ticks(PHASE_TICKS);
    settle();
    apply_setting(CTR_W'($urandom), CTR_W'($urandom), THR_W'($urandom_range(100000, 1)), 1'b1);
    random_ticks(PHASE_TICKS);
    settle();

    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
